### src/ssd_pkg.sv
package ssd_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int CNT_W = $clog2(DIGIT_COUNT + 1);
    localparam int SEL_W = 4;

    localparam logic KIND_RX   = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_BLANK = 8'h20;
    localparam logic [7:0] SEG_OFF    = 8'hff;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic             out_kind;
        logic [7:0]       tx_byte;
        logic [SEL_W-1:0] digit_select;
        logic [7:0]       segments;
        logic             last;
    } out_item_t;

    localparam logic [7:0] NUM_SEG [10] = '{
        8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hd8, 8'h80, 8'h90
    };

    localparam logic [7:0] UPPER_SEG [26] = '{
        8'h88, 8'hff, 8'hc6, 8'hff, 8'h86, 8'h8e, 8'hc2, 8'h89, 8'hcf, 8'he1,
        8'h8a, 8'hc7, 8'hc8, 8'hab, 8'hc0, 8'h8c, 8'h98, 8'haf, 8'h92, 8'h87,
        8'hc1, 8'hc1, 8'hd5, 8'h89, 8'h91, 8'ha4
    };

    localparam logic [7:0] LOWER_SEG [26] = '{
        8'ha0, 8'h83, 8'ha7, 8'ha1, 8'h84, 8'h8e, 8'h90, 8'h8b, 8'hef, 8'hf1,
        8'h8a, 8'hf9, 8'hab, 8'hab, 8'ha3, 8'h8c, 8'h98, 8'haf, 8'h92, 8'h87,
        8'he3, 8'he3, 8'hd5, 8'h89, 8'h91, 8'ha4
    };

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= 8'h30) && (ch <= 8'h39);
    endfunction

    function automatic logic is_upper(input logic [7:0] ch);
        return (ch >= 8'h41) && (ch <= 8'h5a);
    endfunction

    function automatic logic is_lower(input logic [7:0] ch);
        return (ch >= 8'h61) && (ch <= 8'h7a);
    endfunction

    function automatic logic is_alnum(input logic [7:0] ch);
        return is_digit(ch) || is_upper(ch) || is_lower(ch);
    endfunction

    function automatic logic [7:0] seg_of(input logic [7:0] ch);
        logic [7:0] seg;
        seg = SEG_OFF;
        if (is_digit(ch))
        begin
            seg = NUM_SEG[4'(ch - 8'h30)];
        end
        else if (is_upper(ch))
        begin
            seg = UPPER_SEG[5'(ch - 8'h41)];
        end
        else if (is_lower(ch))
        begin
            seg = LOWER_SEG[5'(ch - 8'h61)];
        end
        return seg;
    endfunction

endpackage

### src/serial_fed_seven_segment_driver.sv
// Serial-fed seven-segment driver. Each input transfer is either a received
// byte (kind 0) or a scan tick (kind 1). Every byte is echoed; alphanumerics
// are collected up to DIGIT_COUNT, and a carriage return echoes itself plus a
// newline and latches the collection into the display, newest character on
// digit 0, older ones after it, blanks on the unused digits. A tick steps the
// digit index and gives a one-hot digit select with the active-low segment
// pattern of that digit. All work goes combinationally into a single result
// register, so an item is taken every cycle while results drain; a carriage
// return holds the input until its newline follows the echo into that register.
module serial_fed_seven_segment_driver (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ssd_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ssd_pkg::out_item_t out_data
);
    import ssd_pkg::*;

    logic [7:0]       pend_reg [DIGIT_COUNT];
    logic [CNT_W-1:0] pend_cnt_reg, pend_cnt_next;
    logic [7:0]       shown_reg [DIGIT_COUNT];
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;
    logic             lf_pend_reg, lf_pend_next;

    logic in_xfer;
    logic out_xfer;
    logic is_cr;
    logic collect;
    logic [SEL_W-1:0] sel;

    assign out_xfer  = out_valid_reg && out_ready;
    assign in_ready  = !lf_pend_reg && (!out_valid_reg || out_ready);
    assign in_xfer   = in_valid && in_ready;
    assign is_cr     = (in_data.kind == KIND_RX) && (in_data.rx_byte == CHAR_CR);
    assign collect   = in_xfer && (in_data.kind == KIND_RX) && is_alnum(in_data.rx_byte)
                       && (pend_cnt_reg < CNT_W'(DIGIT_COUNT));
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // wrap after the last digit
    always_comb
    begin
        if (scan_reg == IDX_W'(DIGIT_COUNT - 1))
        begin
            scan_next = '0;
        end
        else
        begin
            scan_next = scan_reg + 1'b1;
        end
    end

    always_comb
    begin
        for (int b = 0; b < SEL_W; b++)
        begin
            sel[b] = (b < DIGIT_COUNT) && (32'(scan_next) == b);
        end
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        lf_pend_next   = lf_pend_reg;
        pend_cnt_next  = pend_cnt_reg;
        if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
        if (lf_pend_reg && out_xfer)
        begin
            out_next.out_kind     = KIND_RX;
            out_next.tx_byte      = CHAR_LF;
            out_next.digit_select = '0;
            out_next.segments     = '0;
            out_next.last         = 1'b1;
            out_valid_next        = 1'b1;
            lf_pend_next          = 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_next = 1'b1;
            if (in_data.kind == KIND_TICK)
            begin
                out_next.out_kind     = KIND_TICK;
                out_next.tx_byte      = '0;
                out_next.digit_select = sel;
                out_next.segments     = seg_of(shown_reg[scan_next]);
                out_next.last         = 1'b1;
            end
            else
            begin
                out_next.out_kind     = KIND_RX;
                out_next.tx_byte      = in_data.rx_byte;
                out_next.digit_select = '0;
                out_next.segments     = '0;
                out_next.last         = !is_cr;
                lf_pend_next          = is_cr;
                if (is_cr)
                begin
                    pend_cnt_next = '0;
                end
                else if (collect)
                begin
                    pend_cnt_next = pend_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            lf_pend_reg   <= 1'b0;
            pend_cnt_reg  <= '0;
            scan_reg      <= '0;
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                shown_reg[i] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            lf_pend_reg   <= lf_pend_next;
            pend_cnt_reg  <= pend_cnt_next;
            if (in_xfer && (in_data.kind == KIND_TICK))
            begin
                scan_reg <= scan_next;
            end
            // newest character sits in slot 0, so it lands on digit 0
            if (in_xfer && is_cr)
            begin
                for (int i = 0; i < DIGIT_COUNT; i++)
                begin
                    if (CNT_W'(i) < pend_cnt_reg)
                    begin
                        shown_reg[i] <= pend_reg[i];
                    end
                    else
                    begin
                        shown_reg[i] <= CHAR_BLANK;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (collect)
        begin
            pend_reg[0] <= in_data.rx_byte;
            for (int i = 1; i < DIGIT_COUNT; i++)
            begin
                pend_reg[i] <= pend_reg[i-1];
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        lf_pend_reg |-> (out_valid_reg && !out_reg.last && (out_reg.tx_byte == CHAR_CR)))
        else $error("newline pending without a carriage-return echo held");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && is_cr) |=> (out_valid && lf_pend_reg && (pend_cnt_reg == '0)))
        else $error("carriage return did not clear collection or queue newline");

    assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg <= CNT_W'(DIGIT_COUNT))
        else $error("collection count overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.out_kind == KIND_TICK)) |->
            ($onehot0(out_data.digit_select) && out_data.last))
        else $error("bad display update");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import ssd_pkg::*;

    localparam logic OUT_ECHO  = 1'b0;
    localparam logic OUT_DRIVE = 1'b1;

    // active-low patterns, bit 7 is the decimal point
    localparam logic [7:0] DIGIT_PAT [10] = '{
        8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hd8, 8'h80, 8'h90
    };
    localparam logic [7:0] UPPER_PAT [26] = '{
        8'h88, 8'hff, 8'hc6, 8'hff, 8'h86, 8'h8e, 8'hc2, 8'h89, 8'hcf, 8'he1,
        8'h8a, 8'hc7, 8'hc8, 8'hab, 8'hc0, 8'h8c, 8'h98, 8'haf, 8'h92, 8'h87,
        8'hc1, 8'hc1, 8'hd5, 8'h89, 8'h91, 8'ha4
    };
    localparam logic [7:0] LOWER_PAT [26] = '{
        8'ha0, 8'h83, 8'ha7, 8'ha1, 8'h84, 8'h8e, 8'h90, 8'h8b, 8'hef, 8'hf1,
        8'h8a, 8'hf9, 8'hab, 8'hab, 8'ha3, 8'h8c, 8'h98, 8'haf, 8'h92, 8'h87,
        8'he3, 8'he3, 8'hd5, 8'h89, 8'h91, 8'ha4
    };

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    serial_fed_seven_segment_driver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    // predictor state
    logic [7:0] held_chars [DIGIT_COUNT];
    int         held_count = 0;
    logic [7:0] shown_chars [DIGIT_COUNT] = '{default: 8'h00};
    int         scan_pos = 0;

    in_item_t   byte_tick_q [$];
    out_item_t  drive_q [$];

    int   errors = 0;
    logic in_took = 1'b0;
    logic out_took = 1'b0;
    int   in_gap = 0;
    int   out_gap = 0;
    logic no_idle = 1'b0;
    int   stall_reqs = 0;
    int   stall_seen = 0;
    int   stall_cnt = 0;

    function automatic logic is_letter_or_digit(input logic [7:0] ch);
        return (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5a) ||
               (ch >= 8'h61 && ch <= 8'h7a);
    endfunction

    function automatic logic [7:0] pattern_of(input logic [7:0] ch);
        if (ch >= 8'h30 && ch <= 8'h39)
            return DIGIT_PAT[int'(ch) - 'h30];
        if (ch >= 8'h41 && ch <= 8'h5a)
            return UPPER_PAT[int'(ch) - 'h41];
        if (ch >= 8'h61 && ch <= 8'h7a)
            return LOWER_PAT[int'(ch) - 'h61];
        return SEG_OFF;
    endfunction

    function automatic void advance_display(input in_item_t it);
        out_item_t r;
        r = '0;
        if (it.kind == KIND_TICK)
        begin
            scan_pos = (scan_pos + 1) % DIGIT_COUNT;
            r.out_kind = OUT_DRIVE;
            r.digit_select = (scan_pos < SEL_W) ? SEL_W'(1 << scan_pos) : '0;
            r.segments = pattern_of(shown_chars[scan_pos]);
            r.last = 1'b1;
            drive_q.push_back(r);
        end
        else if (it.rx_byte == CHAR_CR)
        begin
            // newest character lands on digit 0
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                shown_chars[i] = (i < held_count) ? held_chars[held_count - 1 - i] : CHAR_BLANK;
            end
            held_count = 0;
            r.out_kind = OUT_ECHO;
            r.tx_byte = CHAR_CR;
            drive_q.push_back(r);
            r.tx_byte = CHAR_LF;
            r.last = 1'b1;
            drive_q.push_back(r);
        end
        else
        begin
            if (is_letter_or_digit(it.rx_byte) && held_count < DIGIT_COUNT)
            begin
                held_chars[held_count] = it.rx_byte;
                held_count++;
            end
            r.out_kind = OUT_ECHO;
            r.tx_byte = it.rx_byte;
            r.last = 1'b1;
            drive_q.push_back(r);
        end
    endfunction

    task automatic flag_mismatch(input string what);
        errors++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (drive_q.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected result %h", got));
            return;
        end
        want = drive_q.pop_front();
        if (got.out_kind !== want.out_kind)
            flag_mismatch($sformatf("out_kind got %h want %h", got.out_kind, want.out_kind));
        if (got.tx_byte !== want.tx_byte)
            flag_mismatch($sformatf("tx_byte got %h want %h", got.tx_byte, want.tx_byte));
        if (got.digit_select !== want.digit_select)
            flag_mismatch($sformatf("digit_select got %h want %h",
                                    got.digit_select, want.digit_select));
        if (got.segments !== want.segments)
            flag_mismatch($sformatf("segments got %h want %h", got.segments, want.segments));
        if (got.last !== want.last)
            flag_mismatch($sformatf("last got %h want %h", got.last, want.last));
    endtask

    // sample transfers on the rising edge
    always @(posedge clk)
    begin
        in_took <= rst_n && in_valid && in_ready;
        out_took <= rst_n && out_valid && out_ready;
        if (rst_n && in_valid && in_ready)
            advance_display(in_data);
        if (rst_n && out_valid && out_ready)
            check_result(out_data);
    end

    // sender
    always @(negedge clk)
    begin
        if (in_took || !in_valid)
        begin
            if (in_took)
                in_gap = no_idle ? 0 : $urandom_range(0, 9);
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (byte_tick_q.size() > 0)
            begin
                in_data <= byte_tick_q.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver, with the long hold-off counted here
    always @(negedge clk)
    begin
        if (stall_reqs != stall_seen)
        begin
            stall_seen = stall_reqs;
            stall_cnt = 300;
        end
        if (out_took)
            out_gap = no_idle ? 0 : $urandom_range(0, 9);
        if (stall_cnt > 0)
        begin
            stall_cnt--;
            out_ready <= 1'b0;
        end
        else if (out_gap > 0)
        begin
            out_gap--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        byte_tick_q.push_back(in_item_t'{kind: KIND_RX, rx_byte: b});
    endtask

    task automatic push_tick();
        byte_tick_q.push_back(in_item_t'{kind: KIND_TICK, rx_byte: 8'($urandom_range(0, 255))});
    endtask

    function automatic logic [7:0] any_alnum();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10)
            return 8'(8'h30 + r);
        if (r < 36)
            return 8'(8'h41 + r - 10);
        return 8'(8'h61 + r - 36);
    endfunction

    task automatic fill_block(input int count);
        int made;
        int n;
        int k;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                // a line of characters, the return, then a few scans
                n = $urandom_range(0, 6);
                repeat (n)
                begin
                    if ($urandom_range(0, 7) == 0)
                        push_byte(8'($urandom_range(0, 255)));
                    else
                        push_byte(any_alnum());
                end
                push_byte(CHAR_CR);
                k = $urandom_range(1, 8);
                repeat (k) push_tick();
                made += n + 1 + k;
            end
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    if ($urandom_range(0, 1) == 1)
                        push_tick();
                    else
                        push_byte(8'($urandom_range(0, 255)));
                end
                made += n;
            end
        end
    endtask

    task automatic wait_settled();
        do
            @(posedge clk);
        while (byte_tick_q.size() != 0 || in_valid || drive_q.size() != 0);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // display store still zero, so blank
        push_tick();
        push_tick();
        push_byte(8'h00);
        push_byte(8'hff);
        // fill the collection, then one more that is dropped
        push_byte(8'h30);
        push_byte(8'h39);
        push_byte(8'h41);
        push_byte(8'h5a);
        push_byte(8'h61);
        push_byte(CHAR_CR);
        repeat (4) push_tick();
        // letters, of which B and D have no pattern
        push_byte(8'h61);
        push_byte(8'h7a);
        push_byte(8'h42);
        push_byte(8'h44);
        push_byte(CHAR_CR);
        repeat (4) push_tick();
        // empty collection blanks every digit
        push_byte(CHAR_CR);
        byte_tick_q.push_back(in_item_t'{kind: KIND_TICK, rx_byte: 8'hff});
        byte_tick_q.push_back(in_item_t'{kind: KIND_TICK, rx_byte: 8'h00});
        wait_settled();

        for (int blk = 0; blk < 12; blk++)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            if (blk == 2)
            begin
                no_idle = 1'b1;
                stall_reqs++;
            end
            fill_block(150);
            if (blk == 5)
                wait_settled();
            else
                while (byte_tick_q.size() >= 10) @(posedge clk);
        end

        wait_settled();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
